// File: rtl/ldw_pkg.sv
// Shared types and constants of the character display number writer.
`default_nettype none

package ldw_pkg;

  // Request types
  localparam logic [2:0] REQ_CHAR = 3'd0;
  localparam logic [2:0] REQ_UDEC = 3'd1;
  localparam logic [2:0] REQ_SDEC = 3'd2;
  localparam logic [2:0] REQ_HEX  = 3'd3;
  localparam logic [2:0] REQ_BIN  = 3'd4;

  // Source of an emitted byte
  localparam logic [1:0] SEL_CMD   = 2'd0;
  localparam logic [1:0] SEL_CHAR  = 2'd1;
  localparam logic [1:0] SEL_SIGN  = 2'd2;
  localparam logic [1:0] SEL_DIGIT = 2'd3;

  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;
  localparam logic [4:0] MAX_DIGITS   = 5'd16;
  localparam int unsigned CONV_STEPS  = 16;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [15:0] value;
    logic [4:0]  digit_count;
    logic [7:0]  character;
  } in_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       conv_step;
    logic       emit;
    logic [1:0] sel;
    logic       last;
    logic       dec_cnt;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       line_cmd;
    logic       ndig_zero;
    logic       cnt_one;
    logic       conv_last;
    logic       can_load;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/ldw_dp.sv
// Datapath: request registers, binary to BCD converter, digit select, output register.
`default_nettype none

module ldw_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ldw_pkg::in_t       in_data,
  input  wire ldw_pkg::ctrl_cmd_t cmd,
  output ldw_pkg::dp_stat_t       stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ldw_pkg::out_t           out_data
);

  logic [2:0]  type_r;
  logic [1:0]  line_r;
  logic [4:0]  column_r;
  logic [7:0]  char_r;
  logic        sign_pos_r;
  logic [15:0] mag_r, mag_nxt;
  logic [19:0] bcd_r, bcd_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  ldw_pkg::out_t out_r, out_nxt;

  logic        neg;
  logic [4:0]  ndig_sat;
  logic [19:0] bcd_adj;
  logic [3:0]  idx;
  logic [3:0]  digit;
  logic [7:0]  cmd_byte;
  logic [7:0]  byte_sel;

  assign neg      = (in_data.req_type == ldw_pkg::REQ_SDEC) &&
                    (in_data.value[15] || (in_data.value == 16'd0));
  assign ndig_sat = (in_data.digit_count > ldw_pkg::MAX_DIGITS) ?
                    ldw_pkg::MAX_DIGITS : in_data.digit_count;

  // Double dabble: add 3 to each BCD digit of 5 or more, then shift.
  always_comb begin
    bcd_adj = bcd_r;
    for (int k = 0; k < 5; k++) begin
      if (bcd_r[k*4 +: 4] >= 4'd5) begin
        bcd_adj[k*4 +: 4] = bcd_r[k*4 +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      mag_nxt  = neg ? 16'(~in_data.value + 16'd1) : in_data.value;
      bcd_nxt  = '0;
      step_nxt = '0;
      cnt_nxt  = ndig_sat;
    end else if (cmd.conv_step) begin
      {bcd_nxt, mag_nxt} = {bcd_adj[18:0], mag_r, 1'b0};
      step_nxt = step_r + 4'd1;
    end else if (cmd.dec_cnt) begin
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  // Digit at position cnt-1, zero past the width of the number.
  assign idx = 4'(cnt_r - 5'd1);

  always_comb begin
    if (type_r == ldw_pkg::REQ_HEX) begin
      digit = (idx < 4'd4) ? mag_r[idx[1:0]*4 +: 4] : 4'd0;
    end else if (type_r == ldw_pkg::REQ_BIN) begin
      digit = {3'b000, mag_r[idx]};
    end else begin
      digit = (idx < 4'd5) ? bcd_r[idx*4 +: 4] : 4'd0;
    end
  end

  assign cmd_byte = 8'(ldw_pkg::SET_ADDR_CMD + {3'b000, column_r} - 8'd1 +
                       ((line_r == 2'd2) ? ldw_pkg::LINE2_OFFSET : 8'd0));

  always_comb begin
    unique case (cmd.sel)
      ldw_pkg::SEL_CMD:   byte_sel = cmd_byte;
      ldw_pkg::SEL_CHAR:  byte_sel = char_r;
      ldw_pkg::SEL_SIGN:  byte_sel = sign_pos_r ? 8'h2B : 8'h2D;
      ldw_pkg::SEL_DIGIT: byte_sel = (digit < 4'd10) ? 8'h30 + {4'd0, digit}
                                                     : 8'h37 + {4'd0, digit};
      default:            byte_sel = cmd_byte;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_nxt.is_data  = (cmd.sel != ldw_pkg::SEL_CMD);
      out_nxt.bus_byte = byte_sel;
      out_nxt.last     = cmd.last;
      out_valid_nxt    = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r     <= in_data.req_type;
      line_r     <= in_data.line;
      column_r   <= in_data.column;
      char_r     <= in_data.character;
      sign_pos_r <= !neg;
    end
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  assign stat.req_type  = type_r;
  assign stat.line_cmd  = (line_r == 2'd1) || (line_r == 2'd2);
  assign stat.ndig_zero = (cnt_r == 5'd0);
  assign stat.cnt_one   = (cnt_r == 5'd1);
  assign stat.conv_last = (step_r == 4'(ldw_pkg::CONV_STEPS - 1));
  assign stat.can_load  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/ldw_ctrl.sv
// Controller: sequences load, conversion and byte emission for one request.
`default_nettype none

module ldw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ldw_pkg::dp_stat_t stat,
  output ldw_pkg::ctrl_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_CONV   = 3'd2;
  localparam logic [2:0] S_CMD    = 3'd3;
  localparam logic [2:0] S_CHAR   = 3'd4;
  localparam logic [2:0] S_SIGN   = 3'd5;
  localparam logic [2:0] S_DIGITS = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] after_cmd;
  logic       cmd_is_last;

  always_comb begin
    if (stat.req_type == ldw_pkg::REQ_CHAR) begin
      after_cmd = S_CHAR;
    end else if (stat.req_type == ldw_pkg::REQ_SDEC) begin
      after_cmd = S_SIGN;
    end else begin
      after_cmd = stat.ndig_zero ? S_IDLE : S_DIGITS;
    end
  end

  assign cmd_is_last = (after_cmd == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.req_type > ldw_pkg::REQ_BIN) begin
          state_nxt = S_IDLE;
        end else if (stat.req_type == ldw_pkg::REQ_UDEC ||
                     stat.req_type == ldw_pkg::REQ_SDEC) begin
          state_nxt = S_CONV;
        end else begin
          state_nxt = S_CMD;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (!stat.line_cmd) begin
          state_nxt = after_cmd;
        end else if (stat.can_load) begin
          cmd.emit  = 1'b1;
          cmd.sel   = ldw_pkg::SEL_CMD;
          cmd.last  = cmd_is_last;
          state_nxt = after_cmd;
        end
      end
      S_CHAR: begin
        if (stat.can_load) begin
          cmd.emit  = 1'b1;
          cmd.sel   = ldw_pkg::SEL_CHAR;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SIGN: begin
        if (stat.can_load) begin
          cmd.emit  = 1'b1;
          cmd.sel   = ldw_pkg::SEL_SIGN;
          cmd.last  = stat.ndig_zero;
          state_nxt = stat.ndig_zero ? S_IDLE : S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (stat.can_load) begin
          cmd.emit    = 1'b1;
          cmd.sel     = ldw_pkg::SEL_DIGIT;
          cmd.last    = stat.cnt_one;
          cmd.dec_cnt = 1'b1;
          if (stat.cnt_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.can_load)
    else $error("byte emitted while output register full");

  a_last_ends_req: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.last |=> state_r == S_IDLE)
    else $error("last byte did not end the request");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.sel == ldw_pkg::SEL_DIGIT |-> !stat.ndig_zero)
    else $error("digit emitted with no digits left");

  a_conv_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CONV |->
      (stat.req_type == ldw_pkg::REQ_UDEC || stat.req_type == ldw_pkg::REQ_SDEC))
    else $error("conversion run for a non-decimal request");
`endif

endmodule

`default_nettype wire

// File: rtl/lcd_number_display_writer.sv
// Top level of the character display number writer: controller plus datapath.
//
// Usage: each input beat on in_* (valid/ready) is one display request: a
// character, unsigned or signed decimal, hex or binary value, with line,
// column and digit count. The block answers with a stream of output beats on
// out_*, one bus byte each: an optional set-address command (lines 1 and 2
// only), then the sign byte of a signed request, then the digits MSB first.
// The final byte of a request carries last. Request types 5 to 7 and requests
// that produce nothing give no beats at all.
// Timing: one request is worked on at a time. After acceptance the S_DECIDE
// state decodes the request; decimal requests then pass through the
// shift-add-3 binary to BCD converter. For types 0 to 4 the cursor-command
// slot (S_CMD) always follows, sent or not; then one data byte leaves per
// cycle while the output register can take it, up to 17. in_ready is high
// again in the cycle right after the edge that loads the last byte. The output
// register holds a byte while out_ready is low; emission simply pauses and
// nothing is lost. Reset (rst_n low, synchronous) returns the sequencer to
// idle and empties the output register.
`default_nettype none

module lcd_number_display_writer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ldw_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ldw_pkg::out_t      out_data
);

  ldw_pkg::ctrl_cmd_t cmd;
  ldw_pkg::dp_stat_t  stat;

  // Sequencer: decides which byte goes out next
  ldw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Request registers, BCD converter and output register
  ldw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: dv/lcd_number_display_writer_tb.sv
// Self-checking testbench for the character display number writer.
`timescale 1ns / 100ps

module lcd_number_display_writer_tb;

  // Request codes with no operation behind them
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  // ASCII used by the formatter
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int N_RANDOM       = 205;
  localparam int IDLE_PCT       = 37;    // chance in 100 that a side idles
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int HOLD_AT        = 60;    // random item that triggers it
  localparam int CALM_FROM      = 110;   // stretch with no idling at all
  localparam int CALM_TO        = 160;
  localparam int DRAIN_AT       = 190;   // sender waits for all bytes here
  localparam int DRAIN_CYCLES   = 64;    // extra wait once every owed byte is out
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
  localparam int MAX_REPORTS    = 10;
  localparam int USE_MODEL      = -1;    // table row checked by the predictor

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  ldw_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  ldw_pkg::out_t out_data;

  lcd_number_display_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes still owed by the block, oldest first
  ldw_pkg::out_t expected_bus_bytes[$];

  // Directed table: one request per row; n_lit >= 0 means the row's expected
  // bytes are typed in and sit in lit_bus_bytes, USE_MODEL means predict them.
  typedef struct {
    ldw_pkg::in_t req;
    int           n_lit;
  } dir_row_t;

  dir_row_t      dir_rows[$];
  ldw_pkg::out_t lit_bus_bytes[$];

  int  failures      = 0;
  int  mismatches    = 0;
  int  bytes_checked = 0;
  int  reqs_sent     = 0;
  int  holds_done    = 0;
  int  type_cnt[8];
  bit  calm          = 1'b0;  // both sides run flat out while set
  bit  hold_req      = 1'b0;  // ask the receiver for one long hold-off

  function automatic ldw_pkg::out_t beat(bit is_data, logic [7:0] b, bit last);
    ldw_pkg::out_t o;
    o.is_data  = is_data;
    o.bus_byte = b;
    o.last     = last;
    return o;
  endfunction

  function automatic ldw_pkg::in_t mk_req(logic [2:0] req_type, logic [1:0] line,
                                          logic [4:0] column, logic [15:0] value,
                                          logic [4:0] digit_count,
                                          logic [7:0] character);
    ldw_pkg::in_t r;
    r.req_type    = req_type;
    r.line        = line;
    r.column      = column;
    r.value       = value;
    r.digit_count = digit_count;
    r.character   = character;
    return r;
  endfunction

  // Predictor: byte stream that one request puts on the display bus.
  function automatic void format_request(ldw_pkg::in_t r);
    ldw_pkg::out_t bytes[$];
    logic [4:0]    nd;
    logic [15:0]   mag;
    logic [3:0]    digs[16];
    logic [7:0]    ch;
    int unsigned   base;
    int unsigned   m;
    int unsigned   d;
    int            i;
    // unused request types: nothing at all, not even the cursor command
    if (r.req_type > ldw_pkg::REQ_BIN) return;
    nd = (r.digit_count > ldw_pkg::MAX_DIGITS) ? ldw_pkg::MAX_DIGITS : r.digit_count;
    // set-address command, column 0 wraps below the line base
    if (r.line == 2'd1) begin
      bytes.push_back(beat(1'b0, ldw_pkg::SET_ADDR_CMD + 8'(r.column) - 8'd1, 1'b0));
    end else if (r.line == 2'd2) begin
      bytes.push_back(beat(1'b0, ldw_pkg::SET_ADDR_CMD + ldw_pkg::LINE2_OFFSET +
                                 8'(r.column) - 8'd1, 1'b0));
    end
    mag  = r.value;
    base = 2;
    case (r.req_type)
      ldw_pkg::REQ_CHAR: begin
        bytes.push_back(beat(1'b1, r.character, 1'b0));
      end
      ldw_pkg::REQ_UDEC: begin
        base = 10;
      end
      ldw_pkg::REQ_SDEC: begin
        base = 10;
        // '+' only above zero; zero shows '-'; -32768 negates to itself
        if (!r.value[15] && r.value != 16'h0000) begin
          bytes.push_back(beat(1'b1, CH_PLUS, 1'b0));
        end else begin
          bytes.push_back(beat(1'b1, CH_MINUS, 1'b0));
          mag = 16'h0000 - r.value;
        end
      end
      ldw_pkg::REQ_HEX: begin
        base = 16;
      end
      default: begin
        base = 2;
      end
    endcase
    if (r.req_type != ldw_pkg::REQ_CHAR) begin
      // positions beyond the number fall out as '0'
      m = {16'd0, mag};
      for (i = 0; i < 16; i++) begin
        digs[i] = 4'(m % base);
        m       = m / base;
      end
      for (i = int'(nd); i > 0; i--) begin
        d  = {28'd0, digs[i-1]};
        ch = (d < 10) ? CH_ZERO + 8'(d) : CH_A + 8'(d - 10);
        bytes.push_back(beat(1'b1, ch, 1'b0));
      end
    end
    if (bytes.size() > 0) bytes[bytes.size()-1].last = 1'b1;
    foreach (bytes[k]) expected_bus_bytes.push_back(bytes[k]);
  endfunction

  task automatic add_row(ldw_pkg::in_t r, int n_lit, ldw_pkg::out_t b0, ldw_pkg::out_t b1,
                         ldw_pkg::out_t b2, ldw_pkg::out_t b3);
    dir_row_t      row;
    ldw_pkg::out_t lit[4];
    row.req   = r;
    row.n_lit = n_lit;
    dir_rows.push_back(row);
    lit[0] = b0;
    lit[1] = b1;
    lit[2] = b2;
    lit[3] = b3;
    for (int k = 0; k < n_lit; k++) lit_bus_bytes.push_back(lit[k]);
  endtask

  // Random request: mostly real operations, some unused codes, biased values.
  function automatic ldw_pkg::in_t rand_req();
    ldw_pkg::in_t r;
    int           pick;
    r.req_type = ($urandom_range(99) < 10) ?
                 3'($urandom_range(REQ_RSVD7, REQ_RSVD5)) :
                 3'($urandom_range(ldw_pkg::REQ_BIN, ldw_pkg::REQ_CHAR));
    r.line     = 2'($urandom_range(3));
    r.column   = ($urandom_range(99) < 85) ? 5'($urandom_range(16, 1)) : 5'($urandom);
    pick       = $urandom_range(9);
    case (pick)
      0:       r.value = 16'h0000;
      1:       r.value = 16'h8000;
      2:       r.value = 16'h7FFF;
      3:       r.value = 16'hFFFF;
      4:       r.value = 16'($urandom_range(15));
      default: r.value = 16'($urandom);
    endcase
    r.digit_count = ($urandom_range(99) < 85) ? 5'($urandom_range(16)) : 5'($urandom);
    r.character   = 8'($urandom);
    return r;
  endfunction

  // Present one request from a falling edge; return at the accepting edge.
  task automatic offer_req(ldw_pkg::in_t r);
    in_data  = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    reqs_sent++;
    type_cnt[r.req_type]++;
  endtask

  // Move to the next falling edge, idling the sender now and then.
  task automatic pace_sender();
    @(negedge clk);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_bus_bytes.size() != 0) @(negedge clk);
  endtask

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Output monitor: every byte beat is matched against the oldest expectation.
  always @(posedge clk) begin
    ldw_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (expected_bus_bytes.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat is_data=%0b byte=%02h last=%0b",
                   $realtime, out_data.is_data, out_data.bus_byte, out_data.last);
      end else begin
        want = expected_bus_bytes.pop_front();
        if (out_data.is_data !== want.is_data || out_data.bus_byte !== want.bus_byte ||
            out_data.last !== want.last) begin
          failures++;
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp is_data=%0b byte=%02h last=%0b, got %0b %02h %0b",
                     $realtime, want.is_data, want.bus_byte, want.last,
                     out_data.is_data, out_data.bus_byte, out_data.last);
        end
      end
    end
  end

  // Watchdog: ends a hung run.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: %0d cycles without a beat, %0d bytes outstanding",
                 idle_cycles, expected_bus_bytes.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    ldw_pkg::in_t r;
    int           lit_idx;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (type_cnt[k]) type_cnt[k] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed table ----
    // character requests and the cursor command on every line, column 0 wraps
    add_row(mk_req(ldw_pkg::REQ_CHAR, 2'd1, 5'd1, 16'h0000, 5'd0, 8'h41), 2,
            beat(1'b0, 8'h80, 1'b0), beat(1'b1, 8'h41, 1'b1), '0, '0);
    add_row(mk_req(ldw_pkg::REQ_CHAR, 2'd2, 5'd16, 16'hFFFF, 5'd16, 8'hFF), 2,
            beat(1'b0, 8'hCF, 1'b0), beat(1'b1, 8'hFF, 1'b1), '0, '0);
    add_row(mk_req(ldw_pkg::REQ_CHAR, 2'd0, 5'd0, 16'hFFFF, 5'd31, 8'h00), 1,
            beat(1'b1, 8'h00, 1'b1), '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_CHAR, 2'd1, 5'd0, 16'h1234, 5'd3, 8'h5A), 2,
            beat(1'b0, 8'h7F, 1'b0), beat(1'b1, 8'h5A, 1'b1), '0, '0);
    add_row(mk_req(ldw_pkg::REQ_CHAR, 2'd2, 5'd0, 16'h0000, 5'd0, 8'h7E), 2,
            beat(1'b0, 8'hBF, 1'b0), beat(1'b1, 8'h7E, 1'b1), '0, '0);
    add_row(mk_req(ldw_pkg::REQ_CHAR, 2'd3, 5'd31, 16'h0000, 5'd0, 8'h20), 1,
            beat(1'b1, 8'h20, 1'b1), '0, '0, '0);
    // empty request: no digits and no cursor command
    add_row(mk_req(ldw_pkg::REQ_UDEC, 2'd0, 5'd5, 16'h1234, 5'd0, 8'h00), 0,
            '0, '0, '0, '0);
    // signed with no digits still sends its sign; zero shows a minus
    add_row(mk_req(ldw_pkg::REQ_SDEC, 2'd3, 5'd2, 16'h0005, 5'd0, 8'h00), 1,
            beat(1'b1, CH_PLUS, 1'b1), '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_SDEC, 2'd0, 5'd2, 16'h0000, 5'd3, 8'h00), 4,
            beat(1'b1, CH_MINUS, 1'b0), beat(1'b1, CH_ZERO, 1'b0), beat(1'b1, CH_ZERO, 1'b0),
            beat(1'b1, CH_ZERO, 1'b1));
    // unused request codes send nothing at all
    add_row(mk_req(REQ_RSVD5, 2'd1, 5'd1, 16'hFFFF, 5'd16, 8'hFF), 0, '0, '0, '0, '0);
    add_row(mk_req(REQ_RSVD6, 2'd2, 5'd31, 16'h0000, 5'd31, 8'h00), 0, '0, '0, '0, '0);
    add_row(mk_req(REQ_RSVD7, 2'd3, 5'd16, 16'h8000, 5'd5, 8'hAA), 0, '0, '0, '0, '0);
    // digit rows, checked by the predictor
    add_row(mk_req(ldw_pkg::REQ_UDEC, 2'd1, 5'd1, 16'hFFFF, 5'd5, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_UDEC, 2'd2, 5'd16, 16'h0000, 5'd16, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_UDEC, 2'd1, 5'd31, 16'd12345, 5'd31, 8'hFF), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_UDEC, 2'd3, 5'd3, 16'd5, 5'd17, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_SDEC, 2'd1, 5'd4, 16'h8000, 5'd5, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_SDEC, 2'd2, 5'd5, 16'h7FFF, 5'd6, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_SDEC, 2'd0, 5'd6, 16'hFFFF, 5'd1, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_SDEC, 2'd2, 5'd7, 16'h0001, 5'd5, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_HEX, 2'd1, 5'd8, 16'hFFFF, 5'd4, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_HEX, 2'd2, 5'd9, 16'hABCD, 5'd8, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_HEX, 2'd0, 5'd10, 16'h0000, 5'd16, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_BIN, 2'd1, 5'd31, 16'hAAAA, 5'd16, 8'h00), USE_MODEL,
            '0, '0, '0, '0);
    add_row(mk_req(ldw_pkg::REQ_BIN, 2'd3, 5'd11, 16'h5555, 5'd31, 8'h00), USE_MODEL,
            '0, '0, '0, '0);

    lit_idx = 0;
    foreach (dir_rows[i]) begin
      offer_req(dir_rows[i].req);
      if (dir_rows[i].n_lit == USE_MODEL) begin
        format_request(dir_rows[i].req);
      end else begin
        for (int k = 0; k < dir_rows[i].n_lit; k++) begin
          expected_bus_bytes.push_back(lit_bus_bytes[lit_idx]);
          lit_idx++;
        end
      end
      pace_sender();
    end

    // ---- random requests ----
    for (int n = 0; n < N_RANDOM; n++) begin
      // receiver stalls long while the sender keeps offering: input backs up
      if (n == HOLD_AT) hold_req = 1'b1;
      calm = (n >= CALM_FROM && n < CALM_TO);
      // sender goes quiet until every owed byte is out
      if (n == DRAIN_AT) begin
        in_valid = 1'b0;
        wait_drained();
      end
      r = rand_req();
      offer_req(r);
      format_request(r);
      pace_sender();
    end
    in_valid = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_bus_bytes.size() != 0) begin
      failures++;
      $display("%0d expected bytes never arrived", expected_bus_bytes.size());
    end

    $display("Ran %0d requests (char %0d, udec %0d, sdec %0d, hex %0d, bin %0d, unused %0d)",
             reqs_sent, type_cnt[ldw_pkg::REQ_CHAR], type_cnt[ldw_pkg::REQ_UDEC],
             type_cnt[ldw_pkg::REQ_SDEC], type_cnt[ldw_pkg::REQ_HEX],
             type_cnt[ldw_pkg::REQ_BIN],
             type_cnt[REQ_RSVD5] + type_cnt[REQ_RSVD6] + type_cnt[REQ_RSVD7]);
    $display("%0d bus bytes checked under random stalls, %0d long hold-off(s), %0d mismatches",
             bytes_checked, holds_done, mismatches);

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
